@@ design/pcxrld_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcxrld_pkg
// Shared types and constants of the PCX run-length line decoder.
// ----------------------------------------------------------------------------
package pcxrld_pkg;

  localparam int DIM_W = 12;
  localparam int CNT_W = 6;
  localparam int PIX_W = 8;

  localparam logic [PIX_W-1:0] RUN_MARK  = 8'hC0;
  localparam logic [PIX_W-1:0] RUN_COUNT = 8'h3F;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] bytes_per_line;
    logic [DIM_W-1:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic restart;       // clear all decode state
    logic set_finished;  // mark the image as done
    logic store_marker;  // keep the run count of a marker byte
    logic clear_await;   // drop a zero-count run
    logic step;          // take one column, or close the job
    logic use_job;       // step works on the held job instead of the input
  } cmd_t;

  typedef struct packed {
    logic marker;
    logic awaiting;
    logic zero_run;
    logic image_done;
    logic visible;
    logic finish;
    logic out_free;
  } status_t;

endpackage : pcxrld_pkg
`default_nettype wire

@@ design/pcx_rle_line_decoder_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_rle_line_decoder_core
// Run-length decoder for the image body of an 8-bit PCX picture.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  input    in         in_valid / in_stall   action, data_byte
//  output   out        out_valid / out_stall pixel, row, column, last
//  config   in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Literal bytes, marker bytes, restarts and zero-count runs each take a single
// command. A run value byte is walked column by column; the step that shows the
// last pixel, or the sole step when none is shown, also skips the hidden rest of
// the run at once. The rate is set by the single output register, one pixel per
// cycle while the output is not stalled. Reset is synchronous and restores the
// geometry registers to 320 x 200. Input stalls while a run is in progress, or
// while an item that would show a pixel meets a full, stalled output register.
// ----------------------------------------------------------------------------
module pcx_rle_line_decoder_core
  import pcxrld_pkg::*;
#(
  parameter int MAX_DIM = 4095
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             action,
  input  wire logic [PIX_W-1:0] data_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [PIX_W-1:0]      pixel,
  output logic [DIM_W-1:0]      row,
  output logic [DIM_W-1:0]      column,
  output logic                  last,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [DIM_W-1:0] cfg_data
);

  localparam int DimCapInt = (MAX_DIM > 4095) ? 4095 : MAX_DIM;
  localparam logic [DIM_W-1:0] DimCap = DIM_W'(DimCapInt);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    busy;

  pcxrld_cfg_regs #(
    .DIM_CAP (DimCap)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcxrld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  pcxrld_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel     (pixel),
    .row       (row),
    .column    (column),
    .last      (last)
  );

  // No item is taken while a run is still being emitted.
  assert property (@(posedge clk) disable iff (rst) busy |-> in_stall)
    else $error("input taken during a run");

  // A pixel that is not the last of its item leaves a run in progress.
  assert property (@(posedge clk) disable iff (rst) (out_valid && !last) |-> busy)
    else $error("non-final pixel without an open run");

  // A step that does not close its job must open a run.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.step && !status.finish) |=> busy)
    else $error("unfinished step did not enter a run");

endmodule : pcx_rle_line_decoder_core
`default_nettype wire

@@ design/pcxrld_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcxrld_cfg_regs
// Geometry registers, clamped to the largest supported dimension on write.
// ----------------------------------------------------------------------------
module pcxrld_cfg_regs
  import pcxrld_pkg::*;
#(
  parameter logic [DIM_W-1:0] DIM_CAP = 12'd4095
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [DIM_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_BPL    = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  logic [DIM_W-1:0] clamped;

  assign cfg_ready = 1'b1;
  assign clamped   = (cfg_data > DIM_CAP) ? DIM_CAP : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width    <= 12'd320;
      cfg.bytes_per_line <= 12'd320;
      cfg.image_height   <= 12'd200;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  cfg.image_width    <= clamped;
        REG_BPL:    cfg.bytes_per_line <= clamped;
        REG_HEIGHT: cfg.image_height   <= clamped;
        default: ;
      endcase
    end
  end

endmodule : pcxrld_cfg_regs
`default_nettype wire

@@ design/pcxrld_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcxrld_ctrl
// Sequencer: decides what each input item does and walks runs column by column.
// ----------------------------------------------------------------------------
module pcxrld_ctrl
  import pcxrld_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire logic    action,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  assign busy = (state == ST_RUN);

  always_comb begin
    cmd        = '0;
    in_stall   = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          priority if (action) begin
            cmd.restart = 1'b1;
          end else if (status.image_done) begin
            cmd.set_finished = 1'b1;
          end else if (!status.awaiting && status.marker) begin
            cmd.store_marker = 1'b1;
          end else if (status.zero_run) begin
            cmd.clear_await = 1'b1;
          end else if (status.visible && !status.out_free) begin
            in_stall = 1'b1;
          end else begin
            cmd.step = 1'b1;
            // The item is taken now; the rest of its run is held in the datapath.
            if (!status.finish) state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        in_stall    = 1'b1;
        cmd.use_job = 1'b1;
        if (!status.visible || status.out_free) begin
          cmd.step = 1'b1;
          if (status.finish) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule : pcxrld_ctrl
`default_nettype wire

@@ design/pcxrld_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcxrld_datapath
// Column and row counters, run state and the output register.
// ----------------------------------------------------------------------------
module pcxrld_datapath
  import pcxrld_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cfg_t             cfg,
  input  wire cmd_t             cmd,
  output status_t               status,
  input  wire logic [PIX_W-1:0] data_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [PIX_W-1:0]      pixel,
  output logic [DIM_W-1:0]      row,
  output logic [DIM_W-1:0]      column,
  output logic                  last
);

  logic             awaiting;
  logic [CNT_W-1:0] run_length;
  logic [DIM_W-1:0] col_count;
  logic [DIM_W-1:0] row_count;
  logic             finished;
  logic [CNT_W-1:0] remain;
  logic [PIX_W-1:0] value;

  logic [CNT_W-1:0] cur_len;
  logic [PIX_W-1:0] cur_value;
  logic [DIM_W:0]   col_p1;
  logic [DIM_W:0]   col_end;
  logic [DIM_W-1:0] row_p1;
  logic             visible;
  logic             last_col;
  logic             line_end;

  always_comb begin
    cur_len   = cmd.use_job ? remain : (awaiting ? run_length : CNT_W'(1));
    cur_value = cmd.use_job ? value : data_byte;
    visible   = (col_count < cfg.image_width);
    col_p1    = {1'b0, col_count} + (DIM_W+1)'(1);
    col_end   = {1'b0, col_count} + (DIM_W+1)'(cur_len);
    row_p1    = row_count + DIM_W'(1);
    // This column is the last one shown when the run ends, the line ends, or
    // the next column falls outside the visible width.
    last_col  = (cur_len == CNT_W'(1)) || (col_p1 >= {1'b0, cfg.bytes_per_line})
              || (col_p1 >= {1'b0, cfg.image_width});
    line_end  = (col_end >= {1'b0, cfg.bytes_per_line});

    status.marker     = ((data_byte & RUN_MARK) == RUN_MARK);
    status.awaiting   = awaiting;
    status.zero_run   = awaiting && (run_length == '0);
    status.image_done = finished || (row_count >= cfg.image_height);
    status.visible    = visible;
    status.finish     = last_col || !visible;
    status.out_free   = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting   <= 1'b0;
      run_length <= '0;
      col_count  <= '0;
      row_count  <= '0;
      finished   <= 1'b0;
    end else begin
      if (cmd.restart) begin
        awaiting   <= 1'b0;
        run_length <= '0;
        col_count  <= '0;
        row_count  <= '0;
        finished   <= 1'b0;
      end
      if (cmd.set_finished) finished <= 1'b1;
      if (cmd.store_marker) begin
        awaiting   <= 1'b1;
        run_length <= CNT_W'(data_byte & RUN_COUNT);
      end
      if (cmd.clear_await || (cmd.step && !cmd.use_job)) begin
        awaiting   <= 1'b0;
        run_length <= '0;
      end
      if (cmd.step) begin
        if (status.finish) begin
          // Close the job: skip the hidden remainder of the run in one go.
          if (line_end) begin
            col_count <= '0;
            row_count <= row_p1;
            if ((row_p1 >= cfg.image_height) || (row_p1 == '0)) finished <= 1'b1;
          end else begin
            col_count <= col_end[DIM_W-1:0];
          end
        end else begin
          col_count <= col_p1[DIM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && !status.finish) begin
      remain <= cur_len - CNT_W'(1);
      value  <= cur_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step && visible) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && visible) begin
      pixel  <= cur_value;
      row    <= row_count;
      column <= col_count;
      last   <= last_col;
    end
  end

endmodule : pcxrld_datapath
`default_nettype wire

@@ tb/sv/pcx_rle_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// pcx_rle_tb_pkg
// Register indexes and input actions shared by the line decoder testbench.
// ----------------------------------------------------------------------------
package pcx_rle_tb_pkg;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_BYTES_PER_LINE = 2'd1,
    REG_IMAGE_HEIGHT   = 2'd2
  } dim_reg_e;

  localparam logic ACT_DATA    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

endpackage : pcx_rle_tb_pkg

@@ tb/sv/pcx_rle_pixel_checker.sv @@
// ----------------------------------------------------------------------------
// pcx_rle_pixel_checker
// Watches the decoder's channels, decodes each accepted item on its own copy
// of the line state and compares every emitted pixel with the oldest one due.
// ----------------------------------------------------------------------------
module pcx_rle_pixel_checker
  import pcxrld_pkg::*;
  import pcx_rle_tb_pkg::*;
#(
  parameter int MAX_DIM = 4095
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             action,
  input  logic [PIX_W-1:0] data_byte,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [PIX_W-1:0] pixel,
  input  logic [DIM_W-1:0] row,
  input  logic [DIM_W-1:0] column,
  input  logic             last,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               pixels_checked
);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] column;
    logic             last;
  } pixel_t;

  pixel_t pixels_due[$];

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] pitch_r;
  logic [DIM_W-1:0] height_r;

  logic             awaiting;
  logic [CNT_W-1:0] run_len;
  logic [12:0]      col_cnt;
  logic [DIM_W-1:0] row_cnt;
  logic             done;

  // The newest pixel of an item is held back so that it can carry last.
  pixel_t held;
  bit     have_held;

  int fails = 0;
  int checked = 0;

  function automatic void clear_decode();
    awaiting = 1'b0;
    run_len  = '0;
    col_cnt  = '0;
    row_cnt  = '0;
    done     = 1'b0;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    clamp_dim = (int'(v) > MAX_DIM) ? DIM_W'(MAX_DIM) : v;
  endfunction

  // Consumes one decoded column and reports whether it closed the line.
  function automatic bit take_column(input logic [PIX_W-1:0] value);
    bit line_end;
    if (col_cnt < {1'b0, width_r}) begin
      if (have_held) pixels_due.push_back(held);
      held = {value, row_cnt, col_cnt[DIM_W-1:0], 1'b0};
      have_held = 1'b1;
    end
    line_end = (int'(col_cnt) + 1 >= int'(pitch_r));
    if (line_end) begin
      col_cnt = '0;
      row_cnt = row_cnt + 1'b1;
      if (row_cnt >= height_r || row_cnt == '0) done = 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    return line_end;
  endfunction

  function automatic void decode_item(input logic act, input logic [PIX_W-1:0] b);
    int n;
    have_held = 1'b0;
    if (act == ACT_RESTART) begin
      clear_decode();
      return;
    end
    if (row_cnt >= height_r) done = 1'b1;
    if (done) return;
    if (awaiting) begin
      n = int'(run_len);
      awaiting = 1'b0;
      run_len  = '0;
      for (int i = 0; i < n; i++) begin
        if (take_column(b)) break;
      end
    end else if ((b & RUN_MARK) == RUN_MARK) begin
      run_len  = CNT_W'(b & RUN_COUNT);
      awaiting = 1'b1;
    end else begin
      void'(take_column(b));
    end
    if (have_held) begin
      held.last = 1'b1;
      pixels_due.push_back(held);
    end
  endfunction

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst) begin
      width_r  = 12'd320;
      pitch_r  = 12'd320;
      height_r = 12'd200;
      clear_decode();
      pixels_due.delete();
    end else begin
      // Results go first: a pixel leaving now belongs to an earlier item.
      if (out_valid && !out_stall) begin
        got = {pixel, row, column, last};
        checked++;
        if (pixels_due.size() == 0) begin
          fails++;
          if (fails <= 40)
            $display("%0t: unexpected pixel: expected none, actual pixel=%0d row=%0d col=%0d last=%0d",
                     $time, got.pixel, got.row, got.column, got.last);
        end else begin
          want = pixels_due.pop_front();
          if (got.pixel !== want.pixel || got.row !== want.row ||
              got.column !== want.column || got.last !== want.last) begin
            fails++;
            if (fails <= 40)
              $display("%0t: pixel mismatch: expected %0d r%0d c%0d l%0d, actual %0d r%0d c%0d l%0d",
                       $time, want.pixel, want.row, want.column, want.last,
                       got.pixel, got.row, got.column, got.last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:    width_r  = clamp_dim(cfg_data);
          REG_BYTES_PER_LINE: pitch_r  = clamp_dim(cfg_data);
          REG_IMAGE_HEIGHT:   height_r = clamp_dim(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_item(action, data_byte);
    end
    fail_count     <= fails;
    pending        <= pixels_due.size();
    pixels_checked <= checked;
  end

endmodule : pcx_rle_pixel_checker

@@ tb/sv/tb_pcx_rle_line_decoder_core.sv @@
// ----------------------------------------------------------------------------
// tb_pcx_rle_line_decoder_core
// Drives directed and random encoded lines into the PCX line decoder under
// changing geometry and random stalls; the checker beside it judges pixels.
// ----------------------------------------------------------------------------
module tb_pcx_rle_line_decoder_core;
  import pcxrld_pkg::*;
  import pcx_rle_tb_pkg::*;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 80;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_ITEMS  = 270;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             action = ACT_DATA;
  logic [PIX_W-1:0] data_byte = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] pixel;
  logic [DIM_W-1:0] row;
  logic [DIM_W-1:0] column;
  logic             last;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = REG_IMAGE_WIDTH;
  logic [DIM_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int pixels_checked;

  logic hold_req = 1'b0;
  bit   hold_done = 1'b0;
  int   cycles = 0;
  int   burst_left = 0;
  int   items_sent = 0;
  int   settings = 0;

  always #6 clk = ~clk;

  pcx_rle_line_decoder_core u_top (
    .clk, .rst,
    .in_valid, .in_stall, .action, .data_byte,
    .out_valid, .out_stall, .pixel, .row, .column, .last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  pcx_rle_pixel_checker u_check (
    .clk, .rst,
    .in_valid, .in_stall, .action, .data_byte,
    .out_valid, .out_stall, .pixel, .row, .column, .last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .pixels_checked
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d pixels outstanding.", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output side: stall modes change every so often, plus one long hold-off.
  initial begin
    int mode;
    int left;
    int hold_left;
    mode = 0;
    left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done && hold_left == 0) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
        out_stall <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 1) == 1);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((left % 5) < 2);
        endcase
      end
    end
  end

  task automatic send_item(input logic act, input logic [PIX_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    action    <= act;
    data_byte <= b;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_run(input logic [CNT_W-1:0] count, input logic [PIX_W-1:0] value);
    send_item(ACT_DATA, RUN_MARK | PIX_W'(count));
    send_item(ACT_DATA, value);
  endtask

  // Waits until every pixel has been taken and any hidden run tail has ended.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] pitch,
                           input logic [DIM_W-1:0] h);
    dim_reg_e idx[3];
    logic [DIM_W-1:0] val[3];
    idx = '{REG_IMAGE_WIDTH, REG_BYTES_PER_LINE, REG_IMAGE_HEIGHT};
    val = '{w, pitch, h};
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic logic [DIM_W-1:0] pick_dim(input int lo, input int hi);
    case ($urandom_range(0, 9))
      0:       pick_dim = '0;
      1:       pick_dim = DIM_W'(1);
      2:       pick_dim = {DIM_W{1'b1}};
      default: pick_dim = DIM_W'($urandom_range(lo, hi));
    endcase
  endfunction

  initial begin
    int phase_items;
    int kind;
    logic [DIM_W-1:0] h;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Power-up geometry: literals at both edges of the literal range, one run.
    send_item(ACT_DATA, 8'h00);
    send_item(ACT_DATA, 8'hBF);
    send_run(6'd3, 8'hFF);
    drain();

    configure(12'd5, 12'd7, 12'd3);
    send_item(ACT_RESTART, 8'hC7);
    send_item(ACT_DATA, 8'h7F);
    send_run(6'd0, 8'h12);            // zero-count run
    send_run(6'd63, 8'hC5);           // overshoots the line, value has marker bits
    send_run(6'd2, 8'h80);
    send_item(ACT_DATA, 8'hC4);       // marker dropped by the restart
    send_item(ACT_RESTART, 8'h00);
    send_item(ACT_DATA, 8'h55);
    send_run(6'd63, 8'hAA);
    send_run(6'd63, 8'hBB);
    send_run(6'd63, 8'hCC);           // closes the last line of the image
    send_item(ACT_DATA, 8'h01);       // ignored once the image is done
    send_item(ACT_DATA, 8'hC1);
    send_item(ACT_RESTART, 8'hFF);
    send_item(ACT_DATA, 8'h40);
    drain();

    // Full-width line built from maximum runs, with the output held off for a
    // long stretch so that the decoder fills and stalls its input.
    configure({DIM_W{1'b1}}, {DIM_W{1'b1}}, 12'd2);
    send_item(ACT_RESTART, 8'h00);
    hold_req <= 1'b1;
    for (int i = 0; i < 66; i++) send_run(6'd63, PIX_W'($urandom_range(0, 255)));
    send_item(ACT_DATA, 8'h3F);
    send_item(ACT_DATA, 8'h00);
    drain();

    // Random geometry, mostly well-formed runs and literals with some noise.
    while (items_sent < RANDOM_ITEMS + 160) begin
      h = pick_dim(6, 60);
      configure(pick_dim(1, 24), pick_dim(1, 24), h);
      send_item(ACT_RESTART, PIX_W'($urandom_range(0, 255)));
      phase_items = $urandom_range(15, 40);
      for (int i = 0; i < phase_items; i++) begin
        kind = $urandom_range(0, 19);
        if (kind < 12)
          send_run(CNT_W'($urandom_range(0, 63)), PIX_W'($urandom_range(0, 255)));
        else if (kind < 18)
          send_item(ACT_DATA, PIX_W'($urandom_range(0, 191)));
        else if (kind == 18)
          send_item(ACT_RESTART, PIX_W'($urandom_range(0, 255)));
        else
          send_item(ACT_DATA, PIX_W'($urandom_range(0, 255)));
      end
      drain();
    end

    $display("Covered %0d input items over %0d geometry settings, zero and full scale included.",
             items_sent, settings);
    $display("%0d pixels compared, output held off once for %0d cycles.",
             pixels_checked, LONG_HOLD);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule : tb_pcx_rle_line_decoder_core
